### rtl/nccd_pkg.sv
// shared types, constants and helpers for the nearest-grid-point deposit core
// no dependencies
package nccd_pkg;

	localparam int INTERIOR_CELLS_DEF = 16;
	localparam int GHOST_CELLS_DEF    = 2;
	localparam int THREE_D_DEF        = 1;
	localparam int SPECIES_COUNT_DEF  = 2;

	localparam int WORD_W      = 32;
	localparam int ACC_W       = 48;
	localparam int CELL_W      = 7;   // holds any cell index up to 71
	localparam int CELL_IN_W   = 5;
	localparam int CELL_ADDR_W = 19;  // holds any flat cell address up to 72^3-1
	localparam int PADDR_W     = 5;
	localparam int REG_COUNT   = 8;

	typedef enum logic [1:0] {
		MODE_DEPOSIT = 2'd0,
		MODE_READ    = 2'd1,
		MODE_CLEAR   = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_INV_X    = 3'd3,
		REG_INV_Y    = 3'd4,
		REG_INV_Z    = 3'd5,
		REG_CHARGE_A = 3'd6,
		REG_CHARGE_B = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_DEPOSIT,
		OP_READ,
		OP_READ_ZERO,
		OP_CLEAR
	} op_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_ADDR
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_EXEC
	} back_state_t;

	typedef struct packed {
		logic signed [2:0][WORD_W-1:0] origin;
		logic        [2:0][WORD_W-1:0] inv_cell;
		logic signed [1:0][WORD_W-1:0] charge;
	} cfg_t;

	typedef struct packed {
		op_t                     op;
		logic [CELL_ADDR_W-1:0]  addr;
		logic signed [ACC_W-1:0] charge;
		logic signed [ACC_W-1:0] cur_x;
		logic signed [ACC_W-1:0] cur_y;
		logic signed [ACC_W-1:0] cur_z;
	} job_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// saturating add of two q32.16 accumulators
	function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			sat_add = s[ACC_W-1:0];
		end
	endfunction

endpackage

### rtl/nccd_if.sv
// request and response channel interfaces of the deposit core
// depends on nccd_pkg
interface nccd_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             mode;
	logic [7:0]                             block_offset;
	logic [1:0]                             species;
	logic signed [nccd_pkg::WORD_W-1:0]     pos_x;
	logic signed [nccd_pkg::WORD_W-1:0]     pos_y;
	logic signed [nccd_pkg::WORD_W-1:0]     pos_z;
	logic signed [nccd_pkg::WORD_W-1:0]     vel_x;
	logic signed [nccd_pkg::WORD_W-1:0]     vel_y;
	logic signed [nccd_pkg::WORD_W-1:0]     vel_z;
	logic [nccd_pkg::CELL_IN_W-1:0]         cell_i;
	logic [nccd_pkg::CELL_IN_W-1:0]         cell_j;
	logic [nccd_pkg::CELL_IN_W-1:0]         cell_k;
	modport source (output valid, mode, block_offset, species, pos_x, pos_y, pos_z,
		vel_x, vel_y, vel_z, cell_i, cell_j, cell_k, input ready);
	modport sink (input valid, mode, block_offset, species, pos_x, pos_y, pos_z,
		vel_x, vel_y, vel_z, cell_i, cell_j, cell_k, output ready);
endinterface

interface nccd_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [nccd_pkg::ACC_W-1:0]  density_out;
	logic signed [nccd_pkg::ACC_W-1:0]  current_x_out;
	logic signed [nccd_pkg::ACC_W-1:0]  current_y_out;
	logic signed [nccd_pkg::ACC_W-1:0]  current_z_out;
	modport source (output valid, density_out, current_x_out, current_y_out, current_z_out,
		input ready);
	modport sink (input valid, density_out, current_x_out, current_y_out, current_z_out,
		output ready);
endinterface

### rtl/nccd_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module nccd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// storage write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/nccd_front.sv
// front end: takes requests, finds the particle's cell and forms charge and currents
// depends on nccd_pkg and nccd_req_if
module nccd_front #(
	parameter int INTERIOR_CELLS = nccd_pkg::INTERIOR_CELLS_DEF,
	parameter int GHOST_CELLS    = nccd_pkg::GHOST_CELLS_DEF,
	parameter int THREE_D        = nccd_pkg::THREE_D_DEF,
	parameter int SPECIES_COUNT  = nccd_pkg::SPECIES_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	nccd_req_if.sink         req,
	input  nccd_pkg::cfg_t   cfg,
	input  logic             enable,
	input  nccd_pkg::q_stat_t qs,
	output logic             push,
	output nccd_pkg::job_t   push_job
);
	import nccd_pkg::*;

	localparam int DIM = INTERIOR_CELLS + 2 * GHOST_CELLS;
	localparam logic [WORD_W:0]      G_W    = (WORD_W+1)'(GHOST_CELLS);
	localparam logic [WORD_W:0]      HI_W   = (WORD_W+1)'(DIM - 1 - GHOST_CELLS);
	localparam logic [CELL_W-1:0]    G_C    = CELL_W'(GHOST_CELLS);
	localparam logic [CELL_W-1:0]    DMAX_C = CELL_W'(DIM - 1);
	localparam logic [CELL_W-1:0]    DIM_C  = CELL_W'(DIM);

	front_state_t state_q, state_d;
	logic accept;

	// stage 1: differences, species charge, velocities
	op_t                     op_s1;
	logic                    need_s1;
	logic [CELL_ADDR_W-1:0]  addr_s1;
	logic [2:0]              neg_s1;
	logic [2:0][WORD_W:0]    mag_s1;
	logic [2:0][WORD_W-1:0]  inv_s1;
	logic signed [WORD_W-1:0] q_s1;
	logic signed [2:0][WORD_W-1:0] vel_s1;

	// stage 2: scaled coordinates and current products
	op_t                     op_s2;
	logic                    need_s2;
	logic [CELL_ADDR_W-1:0]  addr_s2;
	logic [2:0]              neg_s2;
	logic [2:0][WORD_W:0]    crd_s2;
	logic signed [ACC_W-1:0] q_s2;
	logic signed [2:0][ACC_W-1:0] cur_s2;

	logic signed [WORD_W:0]  d_in [3];
	logic [2:0][WORD_W-1:0]  pos_in;
	logic [2:0][WORD_W-1:0]  vel_in;
	logic [CELL_W-1:0]       cell_c [3];
	logic                    cell_ok;
	logic [CELL_ADDR_W-1:0]  cell_addr;
	logic [CELL_ADDR_W-1:0]  dep_addr;
	logic                    dep_keep;

	assign accept = req.valid && req.ready;
	assign pos_in = {req.pos_z, req.pos_y, req.pos_x};
	assign vel_in = {req.vel_z, req.vel_y, req.vel_x};

	// request classification and position differences
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			d_in[a] = {pos_in[a][WORD_W-1], pos_in[a]} - {cfg.origin[a][WORD_W-1], cfg.origin[a]};
		end
		cell_ok = ({2'b0, req.cell_i} < DIM_C) && ({2'b0, req.cell_j} < DIM_C) &&
			({2'b0, req.cell_k} < DIM_C);
		cell_addr = (CELL_ADDR_W'(req.cell_k) * CELL_ADDR_W'(DIM) + CELL_ADDR_W'(req.cell_j)) *
			CELL_ADDR_W'(DIM) + CELL_ADDR_W'(req.cell_i);
		dep_keep = (req.block_offset == 8'd0) && ({1'b0, req.species} < 3'(SPECIES_COUNT));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= cell_addr;
			q_s1    <= (req.species == 2'd0) ? cfg.charge[0] : cfg.charge[1];
			vel_s1  <= vel_in;
			inv_s1  <= cfg.inv_cell;
			for (int a = 0; a < 3; a++) begin
				neg_s1[a] <= d_in[a][WORD_W];
				mag_s1[a] <= d_in[a][WORD_W] ? (WORD_W+1)'(-d_in[a]) : d_in[a];
			end
			case (mode_t'(req.mode))
				MODE_DEPOSIT: begin
					op_s1 <= OP_DEPOSIT;
					need_s1 <= dep_keep;
				end
				MODE_READ: begin
					op_s1 <= cell_ok ? OP_READ : OP_READ_ZERO;
					need_s1 <= 1'b1;
				end
				MODE_CLEAR: begin
					op_s1 <= OP_CLEAR;
					need_s1 <= cell_ok;
				end
				default: begin
					op_s1 <= OP_CLEAR;
					need_s1 <= 1'b0;
				end
			endcase
		end
	end

	// multipliers: coordinate scaling and charge times velocity
	always_ff @(posedge clk) begin
		if (state_q == F_MUL) begin
			logic [2*WORD_W:0] p;
			logic signed [2*WORD_W-1:0] c;
			op_s2   <= op_s1;
			need_s2 <= need_s1;
			addr_s2 <= addr_s1;
			neg_s2  <= neg_s1;
			q_s2    <= ACC_W'(q_s1);
			for (int a = 0; a < 3; a++) begin
				p = (2*WORD_W+1)'(mag_s1[a]) * (2*WORD_W+1)'(inv_s1[a]);
				crd_s2[a] <= p[2*WORD_W:WORD_W];
				// element select of a packed array is unsigned, so sign it again
				c = (2*WORD_W)'(q_s1) * (2*WORD_W)'($signed(vel_s1[a]));
				cur_s2[a] <= c[2*WORD_W-1:16];
			end
		end
	end

	// clamp to the ghost-inclusive range and flatten the address
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (neg_s2[a]) begin
				cell_c[a] = (crd_s2[a] >= G_W) ? '0 : G_C - CELL_W'(crd_s2[a]);
			end else begin
				cell_c[a] = (crd_s2[a] > HI_W) ? DMAX_C : CELL_W'(crd_s2[a]) + G_C;
			end
		end
		if (THREE_D == 0) begin
			cell_c[2] = G_C;
		end
		dep_addr = (CELL_ADDR_W'(cell_c[2]) * CELL_ADDR_W'(DIM) + CELL_ADDR_W'(cell_c[1])) *
			CELL_ADDR_W'(DIM) + CELL_ADDR_W'(cell_c[0]);
		push_job.op     = op_s2;
		push_job.addr   = (op_s2 == OP_DEPOSIT) ? dep_addr : addr_s2;
		push_job.charge = q_s2;
		push_job.cur_x  = cur_s2[0];
		push_job.cur_y  = cur_s2[1];
		push_job.cur_z  = cur_s2[2];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: if (accept) begin
				state_d = F_MUL;
			end
			F_MUL: state_d = F_ADDR;
			F_ADDR: if (!need_s2 || !qs.full) begin
				state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready = (state_q == F_IDLE) && enable;
		push      = (state_q == F_ADDR) && need_s2 && !qs.full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### rtl/nccd_fifo.sv
// two-entry queue of decoded jobs between front and back
// depends on nccd_pkg
module nccd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  nccd_pkg::job_t    push_job,
	input  logic              pop,
	output nccd_pkg::job_t    head,
	output nccd_pkg::q_stat_t qs
);
	import nccd_pkg::*;

	job_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign head     = ent_q[rp_q];
	assign qs.full  = (cnt_q == 2'd2);
	assign qs.empty = (cnt_q == 2'd0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

### rtl/nccd_back.sv
// back end: clearing pass, read-modify-write of the cell store, response register
// depends on nccd_pkg, nccd_ram and nccd_rsp_if
module nccd_back #(
	parameter int NCELL = 8000
) (
	input  logic              clk,
	input  logic              arst_n,
	input  nccd_pkg::job_t    head,
	input  nccd_pkg::q_stat_t qs,
	output logic              pop,
	output logic              ready_for_items,
	nccd_rsp_if.source        rsp
);
	import nccd_pkg::*;

	localparam int AW = $clog2(NCELL);
	localparam int RW = 4 * ACC_W;

	back_state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	job_t          job_q;
	logic          out_valid_q;
	logic signed [3:0][ACC_W-1:0] out_q;

	logic          we, re, load;
	logic [AW-1:0] waddr;
	logic [RW-1:0] wdata, rdata;
	logic signed [3:0][ACC_W-1:0] cur, upd;

	// packed as density, x, y, z from the top
	nccd_ram #(.WIDTH(RW), .DEPTH(NCELL)) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(head.addr[AW-1:0]),
		.rdata(rdata)
	);

	// accumulate with saturation
	always_comb begin
		cur = rdata;
		upd[3] = sat_add(cur[3], job_q.charge);
		upd[2] = sat_add(cur[2], job_q.cur_x);
		upd[1] = sat_add(cur[1], job_q.cur_y);
		upd[0] = sat_add(cur[0], job_q.cur_z);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: if (clr_q == AW'(NCELL - 1)) begin
				state_d = B_IDLE;
			end
			B_IDLE: if (!qs.empty) begin
				state_d = B_EXEC;
			end
			B_EXEC: if (job_q.op == OP_DEPOSIT || job_q.op == OP_CLEAR || load) begin
				state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		we    = 1'b0;
		waddr = job_q.addr[AW-1:0];
		wdata = '0;
		load  = 1'b0;
		pop   = (state_q == B_IDLE) && !qs.empty;
		re    = pop;
		case (state_q)
			B_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			B_EXEC: begin
				case (job_q.op)
					OP_DEPOSIT: begin
						we    = 1'b1;
						wdata = upd;
					end
					OP_CLEAR: we = 1'b1;
					default: load = !out_valid_q || rsp.ready;
				endcase
			end
			default: ;
		endcase
		ready_for_items = (state_q != B_CLEAR);
	end

	// job holding and response register
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (load) begin
			out_q <= (job_q.op == OP_READ) ? cur : '0;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.density_out   = out_q[3];
	assign rsp.current_x_out = out_q[2];
	assign rsp.current_y_out = out_q[1];
	assign rsp.current_z_out = out_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

### rtl/ngp_charge_current_deposit_core.sv
// top level: configuration registers, front end, job queue and back end
// depends on nccd_pkg, nccd_if, nccd_front, nccd_fifo, nccd_back
//
// Nearest-grid-point charge and current deposit for one mesh block. Each request
// is handled one at a time by the front end (accept, multiply, then clamp and
// address, which stalls while the job queue is full), and each job in the back end
// is a store read, then a write or response; the front end takes no new request
// until the previous one has left its address step. Only read requests give a response,
// held in an output register until taken. After reset the cell store is swept to
// zero, one cell per cycle, over all (INTERIOR_CELLS+2*GHOST_CELLS)^3 cells
// (8000 by default); no request is taken until then, register writes are.
module ngp_charge_current_deposit_core #(
	parameter int INTERIOR_CELLS = nccd_pkg::INTERIOR_CELLS_DEF,
	parameter int GHOST_CELLS    = nccd_pkg::GHOST_CELLS_DEF,
	parameter int THREE_D        = nccd_pkg::THREE_D_DEF,
	parameter int SPECIES_COUNT  = nccd_pkg::SPECIES_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nccd_pkg::PADDR_W-1:0]  paddr,
	input  logic [nccd_pkg::WORD_W-1:0]   pwdata,
	output logic [nccd_pkg::WORD_W-1:0]   prdata,
	output logic                          pready,
	nccd_req_if.sink                      req,
	nccd_rsp_if.source                    rsp
);
	import nccd_pkg::*;

	localparam int DIM   = INTERIOR_CELLS + 2 * GHOST_CELLS;
	localparam int NCELL = DIM * DIM * DIM;

	cfg_t     cfg_q;
	reg_idx_t widx;
	q_stat_t  qs;
	job_t     push_job, head;
	logic     push, pop, back_ready;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[4:2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin   <= '0;
			cfg_q.inv_cell <= {3{WORD_W'(65536)}};
			cfg_q.charge   <= '0;
		end else if (psel && penable && pwrite) begin
			case (widx)
				REG_ORIGIN_X: cfg_q.origin[0]   <= pwdata;
				REG_ORIGIN_Y: cfg_q.origin[1]   <= pwdata;
				REG_ORIGIN_Z: cfg_q.origin[2]   <= pwdata;
				REG_INV_X:    cfg_q.inv_cell[0] <= pwdata;
				REG_INV_Y:    cfg_q.inv_cell[1] <= pwdata;
				REG_INV_Z:    cfg_q.inv_cell[2] <= pwdata;
				REG_CHARGE_A: cfg_q.charge[0]   <= pwdata;
				REG_CHARGE_B: cfg_q.charge[1]   <= pwdata;
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (widx)
			REG_ORIGIN_X: prdata = cfg_q.origin[0];
			REG_ORIGIN_Y: prdata = cfg_q.origin[1];
			REG_ORIGIN_Z: prdata = cfg_q.origin[2];
			REG_INV_X:    prdata = cfg_q.inv_cell[0];
			REG_INV_Y:    prdata = cfg_q.inv_cell[1];
			REG_INV_Z:    prdata = cfg_q.inv_cell[2];
			REG_CHARGE_A: prdata = cfg_q.charge[0];
			REG_CHARGE_B: prdata = cfg_q.charge[1];
			default:      prdata = '0;
		endcase
	end

	nccd_front #(
		.INTERIOR_CELLS(INTERIOR_CELLS),
		.GHOST_CELLS   (GHOST_CELLS),
		.THREE_D       (THREE_D),
		.SPECIES_COUNT (SPECIES_COUNT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cfg     (cfg_q),
		.enable  (back_ready),
		.qs      (qs),
		.push    (push),
		.push_job(push_job)
	);

	nccd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.qs      (qs)
	);

	nccd_back #(.NCELL(NCELL)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.qs             (qs),
		.pop            (pop),
		.ready_for_items(back_ready),
		.rsp            (rsp)
	);
endmodule

### rtl/nccd_checker.sv
// port-level checks for the deposit core, bound to the top level
// depends on the top level's ports only
module nccd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [47:0] rsp_density
);
	// configuration port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	// one request in flight: front end busy after each accepted request
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one still in front end");

	// stalled response holds its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_density))
		else $error("stalled response changed");
endmodule

bind ngp_charge_current_deposit_core nccd_checker u_nccd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pready     (pready),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_density(rsp.density_out)
);
